@@ sv/pac_pkg.sv @@
// Package for the presence alarm controller.
// Holds the state, command and register index codes, the register set and reset values.
// No dependencies.
`default_nettype none

package pac_pkg;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_NEAR   = 4'b0010,
    ST_STRONG = 4'b0100,
    ST_HOLD   = 4'b1000
  } fsm_state_t;

  typedef enum logic [2:0] {
    CMD_NONE         = 3'd0,
    CMD_FORCE_BUZZER = 3'd1,
    CMD_FORCE_LED1   = 3'd2,
    CMD_FORCE_LED2   = 3'd3,
    CMD_CLEAR        = 3'd4
  } command_t;

  typedef enum logic [2:0] {
    CFG_NEAR_LOW           = 3'd0,
    CFG_NEAR_HIGH          = 3'd1,
    CFG_STRONG_HIGH        = 3'd2,
    CFG_NEAR_QUALIFY_COUNT = 3'd3,
    CFG_HOLD_MS            = 3'd4,
    CFG_ALERT_INTERVAL_MS  = 3'd5,
    CFG_TICK_MS            = 3'd6,
    CFG_BATTERY_LOW_CODE   = 3'd7
  } cfg_index_t;

  localparam int unsigned CfgDataWidth = 24;

  typedef struct packed {
    logic [15:0] near_low;
    logic [15:0] near_high;
    logic [15:0] strong_high;
    logic [7:0]  near_qualify_count;
    logic [23:0] hold_ms;
    logic [23:0] alert_interval_ms;
    logic [15:0] tick_ms;
    logic [10:0] battery_low_code;
  } cfg_t;

  typedef struct packed {
    logic led1;
    logic led2;
    logic buzzer;
  } drive_t;

  localparam logic [15:0] NEAR_LOW_RST           = 16'h00C0;
  localparam logic [15:0] NEAR_HIGH_RST          = 16'h0500;
  localparam logic [15:0] STRONG_HIGH_RST        = 16'h7D00;
  localparam logic [7:0]  NEAR_QUALIFY_COUNT_RST = 8'd1;
  localparam logic [23:0] HOLD_MS_RST            = 24'd7000;
  localparam logic [23:0] ALERT_INTERVAL_MS_RST  = 24'd90000;
  localparam logic [15:0] TICK_MS_RST            = 16'd550;
  localparam logic [10:0] BATTERY_LOW_CODE_RST   = 11'd755;

endpackage

`default_nettype wire

@@ sv/presence_alarm_controller.sv @@
// Top level of the presence alarm controller: register file, input and result stages.
// Depends on pac_pkg, pac_timer and pac_fsm.
//
// One transaction is one sample period and gives exactly one result. The block takes a
// transaction every cycle while no result waits on out_ready: an input register feeds
// single-pass logic that updates the time base, alert limiter and presence state machine and
// loads the result register, so each result passes the input and result registers in turn.
// A result waiting on out_ready stalls the input stage only while that stage is full. The
// user must write registers through cfg_write_en/cfg_index/cfg_data only while no
// transaction is in flight; the block itself does not enforce this.
`default_nettype none

module presence_alarm_controller
  import pac_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write_en,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [CfgDataWidth-1:0] cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [2:0]              command,
  input  wire logic [15:0]             presence_level,
  input  wire logic [9:0]              battery_code,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         led1_drive,
  output logic                         led2_drive,
  output logic                         buzzer_drive,
  output logic                         low_battery_alert
);

  cfg_t        cfg;
  logic        in_full;
  logic [2:0]  command_q;
  logic [15:0] presence_q;
  logic [9:0]  battery_q;
  logic        advance;
  logic [31:0] elapsed_next;
  logic        alert;
  drive_t      drive;
  fsm_state_t  state;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_low           <= NEAR_LOW_RST;
      cfg.near_high          <= NEAR_HIGH_RST;
      cfg.strong_high        <= STRONG_HIGH_RST;
      cfg.near_qualify_count <= NEAR_QUALIFY_COUNT_RST;
      cfg.hold_ms            <= HOLD_MS_RST;
      cfg.alert_interval_ms  <= ALERT_INTERVAL_MS_RST;
      cfg.tick_ms            <= TICK_MS_RST;
      cfg.battery_low_code   <= BATTERY_LOW_CODE_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_NEAR_LOW:           cfg.near_low           <= cfg_data[15:0];
        CFG_NEAR_HIGH:          cfg.near_high          <= cfg_data[15:0];
        CFG_STRONG_HIGH:        cfg.strong_high        <= cfg_data[15:0];
        CFG_NEAR_QUALIFY_COUNT: cfg.near_qualify_count <= cfg_data[7:0];
        CFG_HOLD_MS:            cfg.hold_ms            <= cfg_data[23:0];
        CFG_ALERT_INTERVAL_MS:  cfg.alert_interval_ms  <= cfg_data[23:0];
        CFG_TICK_MS:            cfg.tick_ms            <= cfg_data[15:0];
        CFG_BATTERY_LOW_CODE:   cfg.battery_low_code   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      command_q  <= command;
      presence_q <= presence_level;
      battery_q  <= battery_code;
    end
  end

  pac_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .cfg          (cfg),
    .battery_code (battery_q),
    .elapsed_next (elapsed_next),
    .alert        (alert)
  );

  pac_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .cfg            (cfg),
    .command        (command_q),
    .presence_level (presence_q),
    .elapsed_next   (elapsed_next),
    .drive          (drive),
    .state          (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led1_drive        <= drive.led1;
      led2_drive        <= drive.led2;
      buzzer_drive      <= drive.buzzer;
      low_battery_alert <= alert;
    end
  end

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(command_q) && $stable(presence_q))
    else $error("input stage lost a pending transaction");

  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed transaction gave no result");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> in_ready)
    else $error("empty input stage refused a transaction");

  a_clear_no_hold: assert property (@(posedge clk) disable iff (rst)
    advance && (command_q == CMD_CLEAR) |=> state != ST_HOLD)
    else $error("clear command left state machine in hold");

endmodule

`default_nettype wire

@@ sv/pac_timer.sv @@
// Millisecond time base and low battery alert limiter.
// Depends on pac_pkg for the register set.
`default_nettype none

module pac_timer
  import pac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire cfg_t        cfg,
  input  wire logic [9:0]  battery_code,
  output logic      [31:0] elapsed_next,
  output logic             alert
);

  logic [31:0] elapsed;
  logic [31:0] last_alert;
  logic [31:0] since_alert;

  assign elapsed_next = elapsed + {16'd0, cfg.tick_ms};
  assign since_alert  = elapsed_next - last_alert;
  assign alert = ({1'b0, battery_code} < cfg.battery_low_code) &&
                 (since_alert >= {8'd0, cfg.alert_interval_ms});

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed    <= '0;
      last_alert <= '0;
    end else if (advance) begin
      elapsed <= elapsed_next;
      if (alert) begin
        last_alert <= elapsed_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/pac_fsm.sv @@
// Presence state machine, manual forces and LED/buzzer levels.
// Depends on pac_pkg; takes the advanced time from pac_timer.
`default_nettype none

module pac_fsm
  import pac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire cfg_t        cfg,
  input  wire logic [2:0]  command,
  input  wire logic [15:0] presence_level,
  input  wire logic [31:0] elapsed_next,
  output drive_t           drive,
  output fsm_state_t       state
);

  fsm_state_t  state_next;
  fsm_state_t  prev;
  logic [7:0]  near_run_count;
  logic [7:0]  near_run_count_next;
  logic [7:0]  run_base;
  logic [7:0]  run_inc;
  logic [31:0] hold_start_ms;
  logic [31:0] hold_start_ms_next;
  logic [31:0] since_hold;
  logic        led1_level;
  logic        led2_level;
  logic        buzzer_forced;
  logic        led1_forced;
  logic        led2_forced;
  logic        buzzer_forced_next;
  logic        led1_forced_next;
  logic        led2_forced_next;
  logic        in_near;
  logic        in_strong;
  logic        active;
  logic        toggle;
  logic        led1_toggled;
  logic        led2_toggled;
  logic        is_clear;

  assign is_clear   = (command == CMD_CLEAR);
  assign prev       = is_clear ? ST_IDLE : state;
  assign run_base   = is_clear ? 8'd0 : near_run_count;
  assign run_inc    = run_base + 8'd1;
  assign since_hold = elapsed_next - hold_start_ms;
  assign in_near    = (presence_level >= cfg.near_low) && (presence_level <= cfg.near_high);
  assign in_strong  = (presence_level > cfg.near_high) && (presence_level < cfg.strong_high);

  always_comb begin
    buzzer_forced_next = buzzer_forced;
    led1_forced_next   = led1_forced;
    led2_forced_next   = led2_forced;
    case (command)
      CMD_FORCE_BUZZER: buzzer_forced_next = 1'b1;
      CMD_FORCE_LED1:   led1_forced_next   = 1'b1;
      CMD_FORCE_LED2:   led2_forced_next   = 1'b1;
      CMD_CLEAR: begin
        buzzer_forced_next = 1'b0;
        led1_forced_next   = 1'b0;
        led2_forced_next   = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next          = prev;
    near_run_count_next = run_base;
    hold_start_ms_next  = hold_start_ms;
    case (prev)
      ST_IDLE: begin
        if (in_strong) begin
          near_run_count_next = 8'd0;
          state_next          = ST_STRONG;
        end else if (in_near) begin
          if (run_inc >= cfg.near_qualify_count) begin
            near_run_count_next = 8'd0;
            state_next          = ST_NEAR;
          end else begin
            near_run_count_next = run_inc;
          end
        end else begin
          near_run_count_next = 8'd0;
        end
      end
      ST_NEAR: begin
        if (in_strong) begin
          state_next = ST_STRONG;
        end else if (!in_near) begin
          state_next = ST_IDLE;
        end
      end
      ST_STRONG: begin
        if (!in_strong) begin
          hold_start_ms_next = elapsed_next;
          state_next         = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (since_hold >= {8'd0, cfg.hold_ms}) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    active       = (prev != ST_IDLE);
    toggle       = (prev inside {ST_STRONG, ST_HOLD});
    led1_toggled = toggle ? !led1_level : led1_level;
    led2_toggled = toggle ? !led2_level : led2_level;
    if (state_next inside {ST_STRONG, ST_HOLD}) begin
      drive.led1   = led1_toggled || led1_forced_next;
      drive.led2   = led2_toggled || led2_forced_next;
      drive.buzzer = buzzer_forced_next || active;
    end else begin
      drive.led1   = led1_forced_next || active;
      drive.led2   = led2_forced_next || active;
      drive.buzzer = buzzer_forced_next || active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      near_run_count <= '0;
      hold_start_ms  <= '0;
      led1_level     <= 1'b0;
      led2_level     <= 1'b0;
      buzzer_forced  <= 1'b0;
      led1_forced    <= 1'b0;
      led2_forced    <= 1'b0;
    end else if (advance) begin
      state          <= state_next;
      near_run_count <= near_run_count_next;
      hold_start_ms  <= hold_start_ms_next;
      led1_level     <= drive.led1;
      led2_level     <= drive.led2;
      buzzer_forced  <= buzzer_forced_next;
      led1_forced    <= led1_forced_next;
      led2_forced    <= led2_forced_next;
    end
  end

endmodule

`default_nettype wire

@@ bench/presence_alarm_controller_test.sv @@
// Self-checking testbench for presence_alarm_controller: directed and random sample
// periods with register reprogramming, checked against an in-bench behavioral predictor.
// Depends on pac_pkg and the presence_alarm_controller RTL.
`timescale 1ns / 1ps

module presence_alarm_controller_test;
  import pac_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic led1;
    logic led2;
    logic buzzer;
    logic alert;
  } drive_set_t;

  typedef enum int {ZONE_QUIET, ZONE_NEAR, ZONE_STRONG} zone_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write_en = 1'b0;
  logic [2:0]              cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [2:0]              command = CMD_NONE;
  logic [15:0]             presence_level = '0;
  logic [9:0]              battery_code = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    led1_drive;
  logic                    led2_drive;
  logic                    buzzer_drive;
  logic                    low_battery_alert;

  presence_alarm_controller dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .presence_level    (presence_level),
    .battery_code      (battery_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .led1_drive        (led1_drive),
    .led2_drive        (led2_drive),
    .buzzer_drive      (buzzer_drive),
    .low_battery_alert (low_battery_alert)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cfg_t       shadow_cfg = '{NEAR_LOW_RST, NEAR_HIGH_RST, STRONG_HIGH_RST,
                             NEAR_QUALIFY_COUNT_RST, HOLD_MS_RST, ALERT_INTERVAL_MS_RST,
                             TICK_MS_RST, BATTERY_LOW_CODE_RST};
  fsm_state_t track_state = ST_IDLE;
  logic [7:0]  near_streak = '0;
  logic [31:0] clock_ms = '0;
  logic [31:0] alert_stamp_ms = '0;
  logic [31:0] hold_stamp_ms = '0;
  logic        led1_on = 1'b0;
  logic        led2_on = 1'b0;
  logic        buzzer_pinned = 1'b0;
  logic        led1_pinned = 1'b0;
  logic        led2_pinned = 1'b0;

  drive_set_t expected_drives[$];
  int         error_count = 0;
  int         result_count = 0;
  int         sent_count = 0;
  int         stall_cycles = 0;
  logic       sender_idles = 1'b1;
  logic       receiver_idles = 1'b1;

  function automatic drive_set_t predict_drives(input command_t cmd, input logic [15:0] level,
                                                input logic [9:0] batt);
    drive_set_t res;
    fsm_state_t prior;
    logic       near_hit;
    logic       strong_hit;
    logic       active;
    logic [31:0] since_alert;
    logic [31:0] since_hold;
    res = '0;
    clock_ms = clock_ms + {16'd0, shadow_cfg.tick_ms};
    case (cmd)
      CMD_FORCE_BUZZER: buzzer_pinned = 1'b1;
      CMD_FORCE_LED1:   led1_pinned = 1'b1;
      CMD_FORCE_LED2:   led2_pinned = 1'b1;
      CMD_CLEAR: begin
        buzzer_pinned = 1'b0;
        led1_pinned = 1'b0;
        led2_pinned = 1'b0;
        near_streak = '0;
        track_state = ST_IDLE;
      end
      default: ;
    endcase
    since_alert = clock_ms - alert_stamp_ms;
    if ({1'b0, batt} < shadow_cfg.battery_low_code &&
        since_alert >= {8'd0, shadow_cfg.alert_interval_ms}) begin
      res.alert = 1'b1;
      alert_stamp_ms = clock_ms;
    end
    near_hit = level >= shadow_cfg.near_low && level <= shadow_cfg.near_high;
    strong_hit = level > shadow_cfg.near_high && level < shadow_cfg.strong_high;
    prior = track_state;
    case (prior)
      ST_IDLE: begin
        if (strong_hit) begin
          near_streak = '0;
          track_state = ST_STRONG;
        end else if (near_hit) begin
          near_streak = near_streak + 8'd1;
          if (near_streak >= shadow_cfg.near_qualify_count) begin
            near_streak = '0;
            track_state = ST_NEAR;
          end
        end else begin
          near_streak = '0;
        end
      end
      ST_NEAR: begin
        if (strong_hit) track_state = ST_STRONG;
        else if (!near_hit) track_state = ST_IDLE;
      end
      ST_STRONG: begin
        if (!strong_hit) begin
          hold_stamp_ms = clock_ms;
          track_state = ST_HOLD;
        end
      end
      default: begin
        since_hold = clock_ms - hold_stamp_ms;
        if (since_hold >= {8'd0, shadow_cfg.hold_ms}) track_state = ST_IDLE;
      end
    endcase
    if (prior == ST_STRONG || prior == ST_HOLD) begin
      led1_on = !led1_on;
      led2_on = !led2_on;
    end
    if (track_state == ST_STRONG || track_state == ST_HOLD) begin
      res.buzzer = buzzer_pinned || prior != ST_IDLE;
      if (led1_pinned) led1_on = 1'b1;
      if (led2_pinned) led2_on = 1'b1;
    end else begin
      active = prior != ST_IDLE;
      led1_on = led1_pinned || active;
      led2_on = led2_pinned || active;
      res.buzzer = buzzer_pinned || active;
    end
    res.led1 = led1_on;
    res.led2 = led2_on;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns ERROR %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    drive_set_t got;
    drive_set_t want;
    string      field_names[4];
    field_names = '{"low_battery_alert", "buzzer_drive", "led2_drive", "led1_drive"};
    got = '{led1_drive, led2_drive, buzzer_drive, low_battery_alert};
    out_ready <= !receiver_idles || ($urandom_range(99) >= 7);
    if (!rst && out_valid && out_ready) begin
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                  result_count));
      end else begin
        want = expected_drives.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want[i])
            report_mismatch($sformatf("result %0d %s: expected %0b got %0b",
                                      result_count, field_names[i], want[i], got[i]));
        end
      end
      result_count++;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_sample(input command_t cmd, input logic [15:0] level,
                             input logic [9:0] batt);
    while (sender_idles && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    presence_level <= level;
    battery_code <= batt;
    do @(posedge clk); while (!in_ready);
    expected_drives.push_back(predict_drives(cmd, level, batt));
    sent_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_index_t idx, input logic [CfgDataWidth-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_NEAR_LOW:           shadow_cfg.near_low = value[15:0];
      CFG_NEAR_HIGH:          shadow_cfg.near_high = value[15:0];
      CFG_STRONG_HIGH:        shadow_cfg.strong_high = value[15:0];
      CFG_NEAR_QUALIFY_COUNT: shadow_cfg.near_qualify_count = value[7:0];
      CFG_HOLD_MS:            shadow_cfg.hold_ms = value[23:0];
      CFG_ALERT_INTERVAL_MS:  shadow_cfg.alert_interval_ms = value[23:0];
      CFG_TICK_MS:            shadow_cfg.tick_ms = value[15:0];
      default:                shadow_cfg.battery_low_code = value[10:0];
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(input int unsigned nl, input int unsigned nh,
                             input int unsigned sh, input int unsigned qual,
                             input int unsigned hold, input int unsigned alert,
                             input int unsigned tick, input int unsigned batt_low);
    wait_idle();
    set_reg(CFG_NEAR_LOW, CfgDataWidth'(nl));
    set_reg(CFG_NEAR_HIGH, CfgDataWidth'(nh));
    set_reg(CFG_STRONG_HIGH, CfgDataWidth'(sh));
    set_reg(CFG_NEAR_QUALIFY_COUNT, CfgDataWidth'(qual));
    set_reg(CFG_HOLD_MS, CfgDataWidth'(hold));
    set_reg(CFG_ALERT_INTERVAL_MS, CfgDataWidth'(alert));
    set_reg(CFG_TICK_MS, CfgDataWidth'(tick));
    set_reg(CFG_BATTERY_LOW_CODE, CfgDataWidth'(batt_low));
  endtask

  function automatic command_t pick_command();
    if ($urandom_range(99) < 90) return CMD_NONE;
    return command_t'($urandom_range(4, 1));
  endfunction

  function automatic logic [9:0] pick_battery();
    int unsigned t;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(1) == 0) return 10'($urandom_range(1023));
    t = shadow_cfg.battery_low_code;
    lo = (t > 3) ? t - 3 : 0;
    hi = (t + 3 > 1023) ? 1023 : t + 3;
    if (lo > hi) lo = hi;
    return 10'($urandom_range(hi, lo));
  endfunction

  function automatic logic [15:0] pick_level(input zone_t zone);
    int unsigned nl;
    int unsigned nh;
    int unsigned sh;
    int unsigned top;
    nl = shadow_cfg.near_low;
    nh = shadow_cfg.near_high;
    sh = shadow_cfg.strong_high;
    if ($urandom_range(99) < 8) zone = zone_t'($urandom_range(2));
    case (zone)
      ZONE_NEAR: begin
        if (nl <= nh) return 16'($urandom_range(nh, nl));
      end
      ZONE_STRONG: begin
        if (sh > nh + 1) return 16'($urandom_range(sh - 1, nh + 1));
      end
      default: begin
        top = (sh > nh) ? sh : nh + 1;
        if (nl > 0 && ($urandom_range(1) == 0 || top > 65535))
          return 16'($urandom_range(nl - 1, 0));
        if (top <= 65535) return 16'($urandom_range(65535, top));
      end
    endcase
    return 16'($urandom);
  endfunction

  // quiet samples, a near approach, an optional strong spell, then hold_ms/tick_ms + 0..3 quiet
  task automatic play_visit();
    int quiet_len;
    int near_len;
    int strong_len;
    int hold_len;
    quiet_len = $urandom_range(3);
    near_len = int'(shadow_cfg.near_qualify_count) + $urandom_range(3) - 1;
    strong_len = ($urandom_range(9) < 7) ? $urandom_range(6, 1) : 0;
    hold_len = shadow_cfg.hold_ms / shadow_cfg.tick_ms + $urandom_range(3);
    if (hold_len > 300) hold_len = 300;
    repeat (quiet_len) send_sample(pick_command(), pick_level(ZONE_QUIET), pick_battery());
    repeat (near_len) send_sample(pick_command(), pick_level(ZONE_NEAR), pick_battery());
    if (strong_len > 0) begin
      repeat (strong_len) send_sample(pick_command(), pick_level(ZONE_STRONG), pick_battery());
      repeat (hold_len) send_sample(pick_command(), pick_level(ZONE_QUIET), pick_battery());
    end
  endtask

  task automatic run_visits(input int count);
    int stop;
    stop = sent_count + count;
    while (sent_count < stop) play_visit();
  endtask

  task automatic test_directed_edges();
    send_sample(CMD_NONE, 16'd0, 10'd1023);
    send_sample(CMD_NONE, 16'hFFFF, 10'd0);
    send_sample(CMD_NONE, 16'd191, 10'd1023);
    send_sample(CMD_NONE, 16'd192, 10'd755);
    send_sample(CMD_NONE, 16'd1280, 10'd754);
    send_sample(CMD_NONE, 16'd1281, 10'd1023);
    send_sample(CMD_FORCE_LED1, 16'd31999, 10'd1023);
    send_sample(CMD_NONE, 16'd32000, 10'd1023);
    send_sample(CMD_FORCE_BUZZER, 16'd1281, 10'd0);
    send_sample(CMD_FORCE_LED2, 16'd0, 10'd1023);
    send_sample(CMD_CLEAR, 16'd0, 10'd1023);
    send_sample(CMD_NONE, 16'd20000, 10'd1023);
    send_sample(CMD_CLEAR, 16'd20000, 10'd512);
    send_sample(CMD_FORCE_BUZZER, 16'd20000, 10'd1023);
    send_sample(CMD_CLEAR, 16'd500, 10'd1023);
    send_sample(CMD_FORCE_LED2, 16'd0, 10'd1023);
    send_sample(CMD_FORCE_LED1, 16'd700, 10'd300);
    send_sample(CMD_NONE, 16'd0, 10'd1023);
  endtask

  task automatic test_inverted_bounds();
    load_config(2000, 1000, 500, 2, 550, 5000, 700, 600);
    repeat (80) send_sample(pick_command(), 16'($urandom), pick_battery());
    load_config(3000, 3000, 3001, 1, 900, 2000, 300, 900);
    run_visits(80);
  endtask

  task automatic test_extreme_settings();
    load_config(0, 65535, 65535, 1, 0, 0, 1, 1024);
    run_visits(80);
    load_config(0, 0, 65535, 8, 24'hFFFFFF, 24'hFFFFFF, 65535, 1024);
    run_visits(260);
    load_config(100, 200, 65535, 1, 0, 1000, 65535, 0);
    run_visits(100);
  endtask

  task automatic test_qualify_runs();
    load_config(0, 1000, 40000, 255, 3000, 20000, 300, 800);
    run_visits(260);
    load_config(500, 900, 5000, 3, 1200, 4000, 250, 700);
    run_visits(120);
  endtask

  task automatic test_random_sessions();
    int unsigned nl;
    int unsigned nh;
    int unsigned tick;
    int stop;
    for (int s = 0; s < 4; s++) begin
      nl = $urandom_range(4000);
      nh = nl + $urandom_range(6000);
      tick = $urandom_range(2000, 1);
      load_config(nl, nh, nh + 2 + $urandom_range(20000), $urandom_range(6, 1),
                  tick * $urandom_range(8) + $urandom_range(tick), tick * $urandom_range(30),
                  tick, $urandom_range(1024));
      sender_idles = s != 0;
      receiver_idles = s != 0;
      stop = sent_count + 150;
      while (sent_count < stop) begin
        play_visit();
        if ($urandom_range(3) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_inverted_bounds();
    test_extreme_settings();
    test_qualify_runs();
    test_random_sessions();
    wait_idle();
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
sv/pac_pkg.sv
sv/pac_timer.sv
sv/pac_fsm.sv
sv/presence_alarm_controller.sv
bench/presence_alarm_controller_test.sv
